>>> sv/hnva_pkg.sv
// Shared types and constants for the held-note voice allocator.
`timescale 1ns / 1ps
package hnva_pkg;

   localparam logic [2:0] OP_NOTE_ON  = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF = 3'd1;
   localparam logic [2:0] OP_SUSTAIN  = 3'd2;
   localparam logic [2:0] OP_ALL_OFF  = 3'd3;
   localparam logic [2:0] OP_FINISHED = 3'd4;
   localparam logic [2:0] OP_SWEEP    = 3'd5;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_GATE_OFF = 2'd1;
   localparam logic [1:0] ACT_NONE = 2'd2;

   localparam logic [1:0] MODE_POLY = 2'd0;
   localparam logic [1:0] MODE_MONO = 2'd1;
   localparam logic [1:0] MODE_UNISON = 2'd2;

   localparam logic [1:0] GLIDE_OFF = 2'd0;
   localparam logic [1:0] GLIDE_LEGATO = 2'd2;

   localparam logic [1:0] CSR_VOICE_MODE = 2'd0;
   localparam logic [1:0] CSR_GLIDE_MODE = 2'd1;
   localparam logic [1:0] CSR_MAX_VOICES = 2'd2;
   localparam logic [1:0] CSR_UNISON_COUNT = 2'd3;

   localparam int MAX_RESULTS = 17;

   // One classified event as it travels through the queue.
   typedef struct packed {
      logic [2:0] op;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       pedal_down;
      logic [3:0] finished_voice;
   } event_type;

   // One result item.
   typedef struct packed {
      logic [1:0] action;
      logic [3:0] voice;
      logic [6:0] voice_note;
      logic [6:0] voice_velocity;
      logic       glide;
      logic [6:0] glide_from_note;
      logic       glide_from_valid;
      logic [2:0] unison_lane;
      logic [3:0] unison_size;
      logic       fresh_phrase;
      logic       last;
   } result_type;

endpackage

>>> sv/hnva_queue.sv
// Short event queue between the front end and the voice engine.
`timescale 1ns / 1ps
module hnva_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hnva_pkg::event_type   push_data,
   output logic                  full,
   output logic                  not_empty,
   input  logic                  pop,
   output hnva_pkg::event_type   pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   hnva_pkg::event_type   mem_ff [DEPTH];
   logic [AW-1:0]         wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]           cnt_ff, cnt_in;

   assign full = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) full |-> !push || pop;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_no_underflow;
      @(posedge clock) disable iff (reset) pop |-> not_empty;
   endproperty
   a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

   property p_count_step;
      @(posedge clock) disable iff (reset)
         (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1;
   endproperty
   a_count_step: assert property (p_count_step) else $error("queue count");
endmodule

>>> sv/hnva_engine.sv
// Voice engine: held-note book, voice table and result sequencer.
`timescale 1ns / 1ps
module hnva_engine #(
   parameter int VOICES = 16,
   parameter int BOOK_DEPTH = 16,
   parameter int MAX_UNISON = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  hnva_pkg::event_type   ev,
   output logic                  ev_pop,
   input  logic [1:0]            voice_mode,
   input  logic [1:0]            glide_mode,
   input  logic [4:0]            max_voices,
   input  logic [7:0]            unison_count,
   output logic                  res_valid,
   output hnva_pkg::result_type  res,
   input  logic                  res_stall
);
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int BW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int VCW = $clog2(VOICES + 1);
   localparam int BCW = $clog2(BOOK_DEPTH + 1);
   localparam int RCW = $clog2(hnva_pkg::MAX_RESULTS + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_BSRCH  = 4'd1;  // search book for note
   localparam logic [3:0] ST_BSHIFT = 4'd2;  // full-book drop-oldest shift
   localparam logic [3:0] ST_FREE   = 4'd3;  // poly free-voice / steal scan
   localparam logic [3:0] ST_START  = 4'd4;  // emit starts
   localparam logic [3:0] ST_VSCAN  = 4'd5;  // gate-off scan over voices
   localparam logic [3:0] ST_ORPH   = 4'd6;  // orphan test: book search for voice
   localparam logic [3:0] ST_FALL   = 4'd7;  // mono fallback start
   localparam logic [3:0] ST_NONE   = 4'd8;  // close out the item

   logic [3:0]  st_ff, st_in;
   hnva_pkg::event_type ev_ff, ev_in;

   logic        act_ff [VOICES];
   logic        gate_ff [VOICES];
   logic [6:0]  pitch_ff [VOICES];
   logic [31:0] age_ff [VOICES];
   logic [31:0] clk_ff;
   logic [6:0]  bnote_ff [BOOK_DEPTH];
   logic [6:0]  bvel_ff [BOOK_DEPTH];
   logic [BCW-1:0] bcnt_ff;
   logic [6:0]  prev_note_ff;
   logic        prev_valid_ff, sus_ff;

   logic [VCW-1:0] vi_ff, vi_in;     // voice scan index
   logic [BCW-1:0] bi_ff, bi_in;     // book scan index
   logic [BCW-1:0] bw_ff, bw_in;     // book write index
   logic        found_ff, found_in;
   logic        fresh_ff, fresh_in;
   logic [RCW-1:0] rc_ff, rc_in;
   logic [VCW-1:0] best_ff, best_in;
   logic [31:0] bstamp_ff, bstamp_in;
   logic        frel_ff, frel_in, have_ff, have_in;
   logic [VCW-1:0] nstart_ff, nstart_in;
   logic [3:0]  usize_ff, usize_in;
   logic        gl_ff, gl_in;

   hnva_pkg::result_type res_ff, res_in;
   logic        res_valid_ff, res_valid_in;
   // Gate-off held back one step so the final one can carry last.
   hnva_pkg::result_type pres_ff, pres_in;
   logic        pend_ff, pend_in;

   logic [VCW-1:0] mv;
   logic [3:0]     un;
   logic [VW-1:0]  vx, fin_v;
   logic [BW-1:0]  bx, bwx, btop;

   assign vx = vi_ff[VW-1:0];
   assign bx = bi_ff[BW-1:0];
   assign bwx = bw_ff[BW-1:0];
   assign btop = BW'(bcnt_ff - 1'b1);
   assign fin_v = VW'(ev.finished_voice);
   assign res_valid = res_valid_ff;
   assign res = res_ff;

   always_comb begin
      if (max_voices == 5'd0) mv = VCW'(1);
      else if ({27'd0, max_voices} > VOICES) mv = VCW'(VOICES);
      else mv = VCW'(max_voices);
      if (unison_count == 8'd0) un = 4'd1;
      else if ({24'd0, unison_count} > MAX_UNISON) un = 4'(MAX_UNISON);
      else un = unison_count[3:0];
      if ({28'd0, un} > 32'(mv)) un = 4'(mv);
   end

   // Voice-table and book update strobes driven by the sequencer.
   logic start_en, gate_clr_en, fin_en, book_wr_en, book_cnt_en;
   logic [VW-1:0] start_v, gate_v;
   logic [6:0]    start_note, book_wr_note, book_wr_vel;
   logic [BCW-1:0] book_cnt_val;
   logic [BW-1:0]  book_wr_idx;
   logic prev_en;
   logic [6:0] prev_val;
   logic sus_en;

   hnva_pkg::result_type r;

   always_comb begin
      st_in = st_ff; ev_in = ev_ff;
      vi_in = vi_ff; bi_in = bi_ff; bw_in = bw_ff; found_in = found_ff;
      fresh_in = fresh_ff; rc_in = rc_ff;
      best_in = best_ff; bstamp_in = bstamp_ff; frel_in = frel_ff; have_in = have_ff;
      nstart_in = nstart_ff; usize_in = usize_ff; gl_in = gl_ff;
      res_in = res_ff; res_valid_in = res_valid_ff;
      pres_in = pres_ff; pend_in = pend_ff;
      ev_pop = 1'b0;
      start_en = 1'b0; gate_clr_en = 1'b0; fin_en = 1'b0;
      book_wr_en = 1'b0; book_cnt_en = 1'b0;
      start_v = '0; gate_v = '0; start_note = '0;
      book_wr_note = '0; book_wr_vel = '0; book_cnt_val = bcnt_ff; book_wr_idx = '0;
      prev_en = 1'b0; prev_val = '0; sus_en = 1'b0;
      r = '0;
      r.unison_size = 4'd1;
      if (res_valid_ff && !res_stall) res_valid_in = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (ev_valid) begin
               ev_pop = 1'b1;
               ev_in = ev;
               vi_in = '0; bi_in = '0; bw_in = '0; found_in = 1'b0;
               rc_in = '0; pend_in = 1'b0;
               fresh_in = 1'b1;
               for (int i = 0; i < VOICES; i++) if (act_ff[i]) fresh_in = 1'b0;
               unique case (ev.op)
                  hnva_pkg::OP_NOTE_ON, hnva_pkg::OP_NOTE_OFF: st_in = ST_BSRCH;
                  hnva_pkg::OP_SUSTAIN: begin
                     sus_en = 1'b1;
                     if (sus_ff && !ev.pedal_down) st_in = ST_ORPH;
                     else st_in = ST_NONE;
                  end
                  hnva_pkg::OP_ALL_OFF: begin
                     book_cnt_en = 1'b1; book_cnt_val = '0;
                     st_in = ST_VSCAN;
                  end
                  hnva_pkg::OP_FINISHED: begin
                     fin_en = ({28'd0, ev.finished_voice} < VOICES);
                     st_in = ST_NONE;
                  end
                  hnva_pkg::OP_SWEEP: st_in = ST_ORPH;
                  default: st_in = ST_NONE;
               endcase
            end
         end
         ST_BSRCH: begin
            // Note on: find duplicate, else append or shift. Note off: compact the book in place.
            if (ev_ff.op == hnva_pkg::OP_NOTE_ON) begin
               if (bi_ff < bcnt_ff && bnote_ff[bx] == ev_ff.note) begin
                  book_wr_en = 1'b1; book_wr_idx = bx;
                  book_wr_note = ev_ff.note; book_wr_vel = ev_ff.velocity;
                  st_in = ST_FREE;
               end else if (bi_ff < bcnt_ff) begin
                  bi_in = bi_ff + 1'b1;
               end else if (bcnt_ff < BCW'(BOOK_DEPTH)) begin
                  book_wr_en = 1'b1; book_wr_idx = BW'(bcnt_ff);
                  book_wr_note = ev_ff.note; book_wr_vel = ev_ff.velocity;
                  book_cnt_en = 1'b1; book_cnt_val = bcnt_ff + 1'b1;
                  st_in = ST_FREE;
               end else begin
                  bi_in = BCW'(1); st_in = ST_BSHIFT;
               end
            end else begin
               if (bi_ff < bcnt_ff) begin
                  if (bnote_ff[bx] != ev_ff.note) begin
                     book_wr_en = 1'b1; book_wr_idx = bwx;
                     book_wr_note = bnote_ff[bx]; book_wr_vel = bvel_ff[bx];
                     bw_in = bw_ff + 1'b1;
                  end
                  bi_in = bi_ff + 1'b1;
               end else begin
                  book_cnt_en = 1'b1; book_cnt_val = bw_ff;
                  vi_in = '0;
                  st_in = sus_ff ? ST_NONE : ST_VSCAN;
               end
            end
         end
         ST_BSHIFT: begin
            // Full book: drop oldest, shift down, append new key.
            if (bi_ff < BCW'(BOOK_DEPTH)) begin
               book_wr_en = 1'b1; book_wr_idx = BW'(bi_ff - 1'b1);
               book_wr_note = bnote_ff[bx]; book_wr_vel = bvel_ff[bx];
               bi_in = bi_ff + 1'b1;
            end else begin
               book_wr_en = 1'b1; book_wr_idx = BW'(BOOK_DEPTH - 1);
               book_wr_note = ev_ff.note; book_wr_vel = ev_ff.velocity;
               st_in = ST_FREE;
            end
         end
         ST_FREE: begin
            if (voice_mode == hnva_pkg::MODE_MONO) begin
               nstart_in = VCW'(1); usize_in = 4'd1; best_in = '0;
               gl_in = (bcnt_ff > BCW'(1));
               vi_in = '0; st_in = ST_START;
            end else if (voice_mode == hnva_pkg::MODE_UNISON) begin
               nstart_in = VCW'(un); usize_in = un; gl_in = prev_valid_ff;
               vi_in = '0; st_in = ST_START;
            end else begin
               if (vi_ff == '0 && !found_ff) begin
                  frel_in = 1'b0; have_in = 1'b0; best_in = '0;
                  bstamp_in = 32'hFFFF_FFFF;
               end
               gl_in = (glide_mode != hnva_pkg::GLIDE_OFF) && prev_valid_ff &&
                       (glide_mode != hnva_pkg::GLIDE_LEGATO || bcnt_ff > BCW'(1));
               nstart_in = VCW'(1); usize_in = 4'd1;
               found_in = 1'b1;
               if (vi_ff < mv) begin
                  if (!act_ff[vx]) begin
                     best_in = vi_ff; have_in = 1'b1; vi_in = '0;
                     st_in = ST_START; frel_in = 1'b1;
                     bstamp_in = '0; found_in = 1'b0;
                  end else begin
                     if (!gate_ff[vx] && !((vi_ff == '0) ? 1'b0 : frel_ff)) begin
                        frel_in = 1'b1; best_in = vi_ff; bstamp_in = age_ff[vx];
                        have_in = 1'b1;
                     end else if ((!gate_ff[vx]) == ((vi_ff == '0) ? 1'b0 : frel_ff)
                                  && age_ff[vx] < ((vi_ff == '0) ? 32'hFFFF_FFFF
                                                    : bstamp_ff)) begin
                        best_in = vi_ff; bstamp_in = age_ff[vx]; have_in = 1'b1;
                     end
                     vi_in = vi_ff + 1'b1;
                  end
               end else begin
                  if (!have_ff) best_in = '0;
                  vi_in = '0; found_in = 1'b0; st_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (!res_valid_ff || !res_stall) begin
               start_en = 1'b1;
               start_v = (voice_mode == hnva_pkg::MODE_UNISON) ? vx : best_ff[VW-1:0];
               start_note = ev_ff.note;
               r.action = hnva_pkg::ACT_START;
               r.voice = 4'(start_v);
               r.voice_note = ev_ff.note;
               r.voice_velocity = ev_ff.velocity;
               r.glide = gl_ff;
               r.fresh_phrase = fresh_ff;
               if (voice_mode != hnva_pkg::MODE_MONO) begin
                  r.glide_from_valid = prev_valid_ff;
                  r.glide_from_note = prev_valid_ff ? prev_note_ff : 7'd0;
               end
               if (voice_mode == hnva_pkg::MODE_UNISON) r.unison_lane = 3'(vi_ff);
               r.unison_size = usize_ff;
               r.last = (vi_ff + 1'b1 >= nstart_ff);
               res_in = r; res_valid_in = 1'b1;
               if (vi_ff + 1'b1 >= nstart_ff) begin
                  prev_en = 1'b1; prev_val = ev_ff.note;
                  st_in = ST_IDLE;
               end
               vi_in = vi_ff + 1'b1;
            end
         end
         ST_VSCAN: begin
            // Gate off matching voices (note off) or every gated voice (all off).
            if (!res_valid_ff || !res_stall) begin
               if (vi_ff < VCW'(VOICES)) begin
                  if (gate_ff[vx] && (ev_ff.op == hnva_pkg::OP_ALL_OFF ||
                      (act_ff[vx] && pitch_ff[vx] == ev_ff.note))) begin
                     gate_clr_en = 1'b1; gate_v = vx;
                     if (rc_ff < RCW'(hnva_pkg::MAX_RESULTS)) begin
                        r.action = hnva_pkg::ACT_GATE_OFF; r.voice = 4'(vx);
                        r.voice_note = pitch_ff[vx];
                        // Release the previous gate-off, hold this one.
                        if (pend_ff) begin
                           res_in = pres_ff; res_valid_in = 1'b1;
                        end
                        pres_in = r; pend_in = 1'b1;
                        rc_in = rc_ff + 1'b1;
                     end
                  end
                  vi_in = vi_ff + 1'b1;
               end else if (ev_ff.op == hnva_pkg::OP_NOTE_OFF &&
                            voice_mode == hnva_pkg::MODE_MONO && bcnt_ff != '0) begin
                  st_in = ST_FALL;
               end else begin
                  st_in = ST_NONE;
               end
            end
         end
         ST_ORPH: begin
            // Per voice: search book for its pitch, one entry a cycle unless the result side stalls.
            if (!res_valid_ff || !res_stall) begin
               if (vi_ff >= VCW'(VOICES)) begin
                  st_in = ST_NONE;
               end else if (!(act_ff[vx] && gate_ff[vx])) begin
                  vi_in = vi_ff + 1'b1; bi_in = '0;
               end else if (bi_ff < bcnt_ff && bnote_ff[bx] == pitch_ff[vx]) begin
                  vi_in = vi_ff + 1'b1; bi_in = '0;
               end else if (bi_ff < bcnt_ff) begin
                  bi_in = bi_ff + 1'b1;
               end else begin
                  gate_clr_en = 1'b1; gate_v = vx;
                  if (rc_ff < RCW'(hnva_pkg::MAX_RESULTS)) begin
                     r.action = hnva_pkg::ACT_GATE_OFF; r.voice = 4'(vx);
                     r.voice_note = pitch_ff[vx];
                     if (pend_ff) begin
                        res_in = pres_ff; res_valid_in = 1'b1;
                     end
                     pres_in = r; pend_in = 1'b1;
                     rc_in = rc_ff + 1'b1;
                  end
                  vi_in = vi_ff + 1'b1; bi_in = '0;
               end
            end
         end
         ST_FALL: begin
            // Flush the held gate-off first, then start the newest held key.
            if (!res_valid_ff || !res_stall) begin
               if (pend_ff && rc_ff < RCW'(hnva_pkg::MAX_RESULTS)) begin
                  res_in = pres_ff; res_valid_in = 1'b1; pend_in = 1'b0;
               end else begin
                  start_en = 1'b1; start_v = '0; start_note = bnote_ff[btop];
                  prev_en = 1'b1; prev_val = bnote_ff[btop];
                  if (pend_ff) begin
                     res_in = pres_ff; res_in.last = 1'b1;
                  end else begin
                     r.action = hnva_pkg::ACT_START; r.voice = '0;
                     r.voice_note = bnote_ff[btop]; r.voice_velocity = bvel_ff[btop];
                     r.glide = 1'b1; r.last = 1'b1;
                     res_in = r;
                  end
                  res_valid_in = 1'b1; pend_in = 1'b0;
                  st_in = ST_IDLE;
               end
            end
         end
         ST_NONE: begin
            // Close the item: mark last on the held gate-off, or emit "nothing".
            if (!res_valid_ff || !res_stall) begin
               if (pend_ff) begin
                  res_in = pres_ff; res_in.last = 1'b1;
               end else begin
                  r.action = hnva_pkg::ACT_NONE; r.last = 1'b1;
                  res_in = r;
               end
               res_valid_in = 1'b1; pend_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         res_valid_ff <= 1'b0; pend_ff <= 1'b0;
         clk_ff <= '0; bcnt_ff <= '0;
         prev_note_ff <= '0; prev_valid_ff <= 1'b0; sus_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            act_ff[i] <= 1'b0; gate_ff[i] <= 1'b0;
            pitch_ff[i] <= '0; age_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         res_valid_ff <= res_valid_in; pend_ff <= pend_in;
         if (start_en) begin
            act_ff[start_v] <= 1'b1; gate_ff[start_v] <= 1'b1;
            pitch_ff[start_v] <= start_note;
            age_ff[start_v] <= clk_ff + 1'b1;
            clk_ff <= clk_ff + 1'b1;
         end
         if (gate_clr_en) gate_ff[gate_v] <= 1'b0;
         if (fin_en) begin
            act_ff[fin_v] <= 1'b0;
            gate_ff[fin_v] <= 1'b0;
         end
         if (book_cnt_en) bcnt_ff <= book_cnt_val;
         if (prev_en) begin
            prev_note_ff <= prev_val; prev_valid_ff <= 1'b1;
         end
         if (sus_en) sus_ff <= ev.pedal_down;
      end
      if (book_wr_en) begin
         bnote_ff[book_wr_idx] <= book_wr_note;
         bvel_ff[book_wr_idx] <= book_wr_vel;
      end
      ev_ff <= ev_in; vi_ff <= vi_in; bi_ff <= bi_in; bw_ff <= bw_in;
      found_ff <= found_in; fresh_ff <= fresh_in;
      rc_ff <= rc_in; best_ff <= best_in; bstamp_ff <= bstamp_in;
      frel_ff <= frel_in; have_ff <= have_in; nstart_ff <= nstart_in;
      usize_ff <= usize_in; gl_ff <= gl_in; res_ff <= res_in; pres_ff <= pres_in;
   end

   property p_start_stamps;
      @(posedge clock) disable iff (reset) start_en |=> clk_ff == $past(clk_ff) + 1'b1;
   endproperty
   a_start_stamps: assert property (p_start_stamps) else $error("age clock");

   property p_book_bound;
      @(posedge clock) disable iff (reset) 1'b1 |-> bcnt_ff <= BCW'(BOOK_DEPTH);
   endproperty
   a_book_bound: assert property (p_book_bound) else $error("book count");

   property p_pop_idle;
      @(posedge clock) disable iff (reset) ev_pop |-> st_ff == ST_IDLE;
   endproperty
   a_pop_idle: assert property (p_pop_idle) else $error("pop outside idle");
endmodule

>>> sv/held_note_voice_allocator.sv
// Top level of the held-note voice allocator: front end, queue, voice engine.
// Order: the engine pops an item from the queue while idle. A note on goes through book
// search (or the drop-oldest shift when the book is full) and the free/steal scan before
// its starts; a note off compacts the book and scans the voices unless sustain is down;
// all off empties the book and scans the voices; a sweep searches the book per voice.
// The engine takes one item at a time; the queue holds two more, then stalls requests.
// Stalls on the result side hold the engine. Reset: synchronous, clears voices, book
// count, age clock, sequencer state and the configuration registers.
`timescale 1ns / 1ps
module held_note_voice_allocator #(
   parameter int VOICES = 16,
   parameter int BOOK_DEPTH = 16,
   parameter int MAX_UNISON = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [6:0] req_note,
   input  logic [6:0] req_velocity,
   input  logic       req_pedal_down,
   input  logic [3:0] req_finished_voice,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_action,
   output logic [3:0] rsp_voice,
   output logic [6:0] rsp_voice_note,
   output logic [6:0] rsp_voice_velocity,
   output logic       rsp_glide,
   output logic [6:0] rsp_glide_from_note,
   output logic       rsp_glide_from_valid,
   output logic [2:0] rsp_unison_lane,
   output logic [3:0] rsp_unison_size,
   output logic       rsp_fresh_phrase,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   // Configuration registers: always writable.
   logic [1:0] voice_mode_ff, glide_mode_ff;
   logic [4:0] max_voices_ff;
   logic [7:0] unison_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_mode_ff <= hnva_pkg::MODE_POLY;
         glide_mode_ff <= hnva_pkg::GLIDE_OFF;
         max_voices_ff <= 5'd16;
         unison_count_ff <= 8'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            hnva_pkg::CSR_VOICE_MODE:   voice_mode_ff <= csr_data[1:0];
            hnva_pkg::CSR_GLIDE_MODE:   glide_mode_ff <= csr_data[1:0];
            hnva_pkg::CSR_MAX_VOICES:   max_voices_ff <= csr_data[4:0];
            hnva_pkg::CSR_UNISON_COUNT: unison_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Front end: pack the item and push it into the queue.
   hnva_pkg::event_type req_ev, q_ev;
   logic q_full, q_ne, q_pop;
   hnva_pkg::result_type res;

   assign req_ev = '{op: req_op, note: req_note, velocity: req_velocity,
                     pedal_down: req_pedal_down, finished_voice: req_finished_voice};
   assign req_stall = q_full;

   hnva_queue #(.DEPTH(2)) u_queue (
      .clock(clock), .reset(reset),
      .push(req_valid && !q_full), .push_data(req_ev), .full(q_full),
      .not_empty(q_ne), .pop(q_pop), .pop_data(q_ev)
   );

   hnva_engine #(.VOICES(VOICES), .BOOK_DEPTH(BOOK_DEPTH), .MAX_UNISON(MAX_UNISON)) u_engine (
      .clock(clock), .reset(reset),
      .ev_valid(q_ne), .ev(q_ev), .ev_pop(q_pop),
      .voice_mode(voice_mode_ff), .glide_mode(glide_mode_ff),
      .max_voices(max_voices_ff), .unison_count(unison_count_ff),
      .res_valid(rsp_valid), .res(res), .res_stall(rsp_stall)
   );

   assign rsp_action = res.action;
   assign rsp_voice = res.voice;
   assign rsp_voice_note = res.voice_note;
   assign rsp_voice_velocity = res.voice_velocity;
   assign rsp_glide = res.glide;
   assign rsp_glide_from_note = res.glide_from_note;
   assign rsp_glide_from_valid = res.glide_from_valid;
   assign rsp_unison_lane = res.unison_lane;
   assign rsp_unison_size = res.unison_size;
   assign rsp_fresh_phrase = res.fresh_phrase;
   assign rsp_last = res.last;

   property p_stall_full;
      @(posedge clock) disable iff (reset) req_stall |-> q_full;
   endproperty
   a_stall_full: assert property (p_stall_full) else $error("stall without full");

   property p_csr_mode;
      @(posedge clock) disable iff (reset)
         (csr_valid && csr_index == hnva_pkg::CSR_VOICE_MODE) |=>
            voice_mode_ff == $past(csr_data[1:0]);
   endproperty
   a_csr_mode: assert property (p_csr_mode) else $error("voice mode write");

   property p_size_nonzero;
      @(posedge clock) disable iff (reset) rsp_valid |-> rsp_unison_size != 4'd0;
   endproperty
   a_size_nonzero: assert property (p_size_nonzero) else $error("zero unison size");
endmodule
